// ===== rtl/core/xyzp_pkg.sv =====
// Shared types and character constants of the xyz command frame parser.
package xyzp_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int OUT_WIDTH       = 16;

  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_Y    = 8'h79;
  localparam logic [7:0] CH_Z    = 8'h7A;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_XCNT = 4'd1,
    PH_XDIG = 4'd2,
    PH_YTAG = 4'd3,
    PH_YCNT = 4'd4,
    PH_YDIG = 4'd5,
    PH_ZTAG = 4'd6,
    PH_ZVAL = 4'd7
  } phase_t;

  typedef struct packed {
    logic                        status;
    logic signed [OUT_WIDTH-1:0] x_value;
    logic signed [OUT_WIDTH-1:0] y_value;
    logic                        z_flag;
  } result_t;

endpackage

// ===== rtl/core/xyz_command_frame_parser.sv =====
// Top level of the xyz command frame parser.
// Received bytes arrive one per transfer on the input channel (in_valid, in_ready,
// rx_byte). A frame reads x, count digit, digits, y, count digit, digits, z, then
// T or F. Only a T or F byte yields a result, one transfer on the output channel
// (out_valid, out_ready, status, x_value, y_value, z_flag); other bytes only move
// the parse state. An x byte restarts the frame from any position.
// An accepted byte is held in an input register and is parsed from there; a result
// is written into the result register and shown on the output ports from there.
// One byte is taken every cycle while no terminator byte waits for a busy result
// register; the parse state updates between the input and the result register.
// When the receiver stalls, the result stays in the result register and bytes
// that give no result still flow; a terminator byte waits in the input register
// until the result register is free, and only then is input accepted again.
// Reset empties both registers and returns the parser to idle with both values
// at zero.
module xyz_command_frame_parser #(
  parameter int VALUE_WIDTH = xyzp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [7:0]                               rx_byte,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     status,
  output logic signed [xyzp_pkg::OUT_WIDTH-1:0]    x_value,
  output logic signed [xyzp_pkg::OUT_WIDTH-1:0]    y_value,
  output logic                                     z_flag
);
  import xyzp_pkg::*;

  logic       in_full;
  logic       in_full_next;
  logic [7:0] in_byte;
  logic       is_term;
  logic       advance;
  result_t    parse_result;
  result_t    out_data;

  assign advance  = in_full && (!is_term || !out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_comb begin
    if (in_valid && in_ready) begin
      in_full_next = 1'b1;
    end else if (advance) begin
      in_full_next = 1'b0;
    end else begin
      in_full_next = in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  xyzp_parse #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .rx_byte(in_byte),
    .is_term(is_term),
    .result (parse_result)
  );

  xyzp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && is_term),
    .load_data(parse_result),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  assign status  = out_data.status;
  assign x_value = out_data.x_value;
  assign y_value = out_data.y_value;
  assign z_flag  = out_data.z_flag;

endmodule

// ===== rtl/core/xyzp_parse.sv =====
// Frame state machine and value accumulators; builds the result of a terminator byte.
module xyzp_parse #(
  parameter int VALUE_WIDTH = xyzp_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              is_term,
  output xyzp_pkg::result_t result
);
  import xyzp_pkg::*;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [3:0]             digits_left;
  logic [3:0]             digits_left_next;
  logic [VALUE_WIDTH-1:0] x_accum;
  logic [VALUE_WIDTH-1:0] x_accum_next;
  logic [VALUE_WIDTH-1:0] y_accum;
  logic [VALUE_WIDTH-1:0] y_accum_next;

  logic                   is_digit;
  logic [3:0]             digit_val;
  logic [VALUE_WIDTH-1:0] acc_sel;
  logic [VALUE_WIDTH-1:0] acc_mac;

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit_val = 4'(rx_byte - CH_ZERO);
  assign acc_sel   = (phase == PH_XDIG) ? x_accum : y_accum;
  assign acc_mac   = (acc_sel << 3) + (acc_sel << 1) + VALUE_WIDTH'(digit_val);
  assign is_term   = (rx_byte == CH_T) || (rx_byte == CH_F);

  always_comb begin
    phase_next       = phase;
    digits_left_next = digits_left;
    x_accum_next     = x_accum;
    y_accum_next     = y_accum;
    if (rx_byte == CH_X) begin
      phase_next       = PH_XCNT;
      digits_left_next = '0;
      x_accum_next     = '0;
      y_accum_next     = '0;
    end else if (is_term) begin
      phase_next       = PH_IDLE;
      digits_left_next = '0;
    end else begin
      case (phase)
        PH_XCNT, PH_YCNT: begin
          if (!is_digit) begin
            phase_next = PH_IDLE;
          end else begin
            digits_left_next = digit_val;
            if (digit_val == 4'd0) begin
              phase_next = (phase == PH_XCNT) ? PH_YTAG : PH_ZTAG;
            end else begin
              phase_next = (phase == PH_XCNT) ? PH_XDIG : PH_YDIG;
            end
          end
        end
        PH_XDIG, PH_YDIG: begin
          if (!is_digit) begin
            phase_next       = PH_IDLE;
            digits_left_next = '0;
          end else begin
            if (phase == PH_XDIG) begin
              x_accum_next = acc_mac;
            end else begin
              y_accum_next = acc_mac;
            end
            digits_left_next = digits_left - 4'd1;
            if (digits_left == 4'd1) begin
              phase_next = (phase == PH_XDIG) ? PH_YTAG : PH_ZTAG;
            end
          end
        end
        PH_YTAG: begin
          phase_next = (rx_byte == CH_Y) ? PH_YCNT : PH_IDLE;
        end
        PH_ZTAG: begin
          phase_next = (rx_byte == CH_Z) ? PH_ZVAL : PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    if (phase == PH_ZVAL) begin
      result.status  = 1'b0;
      result.x_value = signed'(OUT_WIDTH'(x_accum));
      result.y_value = signed'(OUT_WIDTH'(y_accum));
      result.z_flag  = (rx_byte == CH_T);
    end else begin
      result.status  = 1'b1;
      result.x_value = '0;
      result.y_value = '0;
      result.z_flag  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      digits_left <= '0;
      x_accum     <= '0;
      y_accum     <= '0;
    end else if (step) begin
      phase       <= phase_next;
      digits_left <= digits_left_next;
      x_accum     <= x_accum_next;
      y_accum     <= y_accum_next;
    end
  end

endmodule

// ===== rtl/core/xyzp_out_reg.sv =====
// Result register that holds one frame result until the receiver takes it.
module xyzp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  xyzp_pkg::result_t load_data,
  input  logic              out_ready,
  output logic              out_valid,
  output xyzp_pkg::result_t out_data
);
  import xyzp_pkg::*;

  logic out_valid_next;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== rtl/core/xyzp_checker.sv =====
// Port-level checks of the xyz command frame parser and their binding.
module xyzp_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic [7:0]                            rx_byte,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  status,
  input logic signed [xyzp_pkg::OUT_WIDTH-1:0] x_value,
  input logic signed [xyzp_pkg::OUT_WIDTH-1:0] y_value,
  input logic                                  z_flag
);

  // A failed frame never carries values.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (x_value == '0) && (y_value == '0) && !z_flag)
    else $error("error result carries non-zero fields");

  // A waiting result is held unchanged until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(x_value)
      && $stable(y_value) && $stable(z_flag))
    else $error("stalled result changed or dropped");

  // An offered byte stays on the input until its transfer.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(rx_byte))
    else $error("offered byte changed or withdrawn");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_reset_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind xyz_command_frame_parser xyzp_checker u_xyzp_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the xyz command frame parser.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xyzp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [7:0]                  rx_byte = 8'd0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        status;
  logic signed [OUT_WIDTH-1:0] x_value;
  logic signed [OUT_WIDTH-1:0] y_value;
  logic                        z_flag;

  logic [7:0] pending_bytes[$];
  result_t    expected_results[$];
  int         queued_total = 0;
  int         frame_bytes = 0;
  int         taken_bytes = 0;
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_requests = 0;
  int         hold_served = 0;
  int         hold_left = 0;
  logic       byte_taken = 1'b0;

  phase_t                     frame_phase = PH_IDLE;
  logic [3:0]                 digits_left = '0;
  logic [VALUE_WIDTH_DEF-1:0] x_acc = '0;
  logic [VALUE_WIDTH_DEF-1:0] y_acc = '0;

  xyz_command_frame_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .x_value   (x_value),
    .y_value   (y_value),
    .z_flag    (z_flag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit parse_rx_byte(input logic [7:0] b, output result_t res);
    logic is_dig;
    res = '0;
    if (b == CH_X) begin
      x_acc = '0;
      y_acc = '0;
      digits_left = '0;
      frame_phase = PH_XCNT;
      return 1'b0;
    end
    if (b == CH_T || b == CH_F) begin
      if (frame_phase == PH_ZVAL) begin
        res.x_value = x_acc[OUT_WIDTH-1:0];
        res.y_value = y_acc[OUT_WIDTH-1:0];
        res.z_flag  = (b == CH_T);
      end else begin
        res.status = 1'b1;
      end
      frame_phase = PH_IDLE;
      digits_left = '0;
      return 1'b1;
    end
    is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
    case (frame_phase)
      PH_XCNT, PH_YCNT: begin
        if (!is_dig) begin
          frame_phase = PH_IDLE;
        end else begin
          digits_left = 4'(b - CH_ZERO);
          if (frame_phase == PH_XCNT) begin
            frame_phase = (digits_left == 0) ? PH_YTAG : PH_XDIG;
          end else begin
            frame_phase = (digits_left == 0) ? PH_ZTAG : PH_YDIG;
          end
        end
      end
      PH_XDIG, PH_YDIG: begin
        if (!is_dig) begin
          frame_phase = PH_IDLE;
          digits_left = '0;
        end else begin
          if (frame_phase == PH_XDIG) begin
            x_acc = VALUE_WIDTH_DEF'(x_acc * 10 + VALUE_WIDTH_DEF'(b - CH_ZERO));
          end else begin
            y_acc = VALUE_WIDTH_DEF'(y_acc * 10 + VALUE_WIDTH_DEF'(b - CH_ZERO));
          end
          digits_left = digits_left - 4'd1;
          if (digits_left == 0) begin
            frame_phase = (frame_phase == PH_XDIG) ? PH_YTAG : PH_ZTAG;
          end
        end
      end
      PH_YTAG: frame_phase = (b == CH_Y) ? PH_YCNT : PH_IDLE;
      PH_ZTAG: frame_phase = (b == CH_Z) ? PH_ZVAL : PH_IDLE;
      default: frame_phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Input transfers feed the predictor; output transfers are checked against it.
  always @(posedge clk) begin
    result_t res;
    result_t want;
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        taken_bytes++;
        if (parse_rx_byte(rx_byte, res)) expected_results.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got status=%0b x=%0d y=%0d z=%0b",
                   $time, status, x_value, y_value, z_flag);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 16'(want.status), 16'(status));
          check_field("x_value", want.x_value, x_value);
          check_field("y_value", want.y_value, y_value);
          check_field("z_flag", 16'(want.z_flag), 16'(z_flag));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        rx_byte  <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      out_ready   <= 1'b0;
      hold_left   <= LONG_HOLD;
      hold_served <= hold_requests;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b);
    pending_bytes.push_back(b);
    queued_total++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // A well-formed frame with random content, sometimes damaged, cut short or followed by an extra terminator.
  task automatic queue_frame();
    logic [7:0] frm[$];
    int         count;
    int         pick;
    bit         nines;
    frm.push_back(CH_X);
    for (int v = 0; v < 2; v++) begin
      if (v == 1) frm.push_back(CH_Y);
      count = $urandom_range(0, 9);
      nines = ($urandom_range(0, 9) == 0);
      frm.push_back(CH_ZERO + 8'(count));
      for (int i = 0; i < count; i++) begin
        frm.push_back(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
      end
    end
    frm.push_back(CH_Z);
    frm.push_back($urandom_range(0, 1) ? CH_T : CH_F);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      frm[$urandom_range(0, frm.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (pick < 20) begin
      pick = $urandom_range(1, frm.size() - 1);
      while (frm.size() > pick) void'(frm.pop_back());
      frm.push_back($urandom_range(0, 1) ? CH_T : CH_F);
    end else if (pick < 24) begin
      frm.push_back($urandom_range(0, 1) ? CH_T : CH_F);
    end
    foreach (frm[i]) push_byte(frm[i]);
    frame_bytes += frm.size();
  endtask

  task automatic queue_random_traffic(int target);
    int start;
    start = frame_bytes;
    while (frame_bytes - start < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      end
      queue_frame();
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (taken_bytes != queued_total || expected_results.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 46;
    queue_text("x532767y532768zT");
    queue_text("T");
    queue_text("x3x0y0zF");
    queue_text("xaT");
    queue_random_traffic(307);
    wait_drained();

    send_idle_pct = 46;
    recv_idle_pct = 9;
    queue_random_traffic(307);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    queue_random_traffic(307);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (expected_results.size() != 0) begin
        $display("%0t ns: %0d expected results never arrived", $time, expected_results.size());
      end
      $display("Verification failed");
    end
    $finish;
  end

endmodule
